[hdl/bfe_pkg.sv]
// Shared types, constants and helpers for the Bezier edge flattener.
// Used by the channel interfaces, controller, datapath and top level.
package bfe_pkg;

  localparam int COORD_W       = 24;
  localparam int SLOPE_W       = 32;
  localparam int LVL_W         = 3;
  localparam int STK_IDX_W     = 3;
  localparam int CNT_W         = 6;
  localparam int MAX_DEPTH_DEF = 6;
  localparam int DIV_STEPS     = 40;
  localparam int TEST_LAST     = 15;
  localparam int RES_CNT_W     = 6;
  localparam int PADDR_W       = 3;
  localparam logic [15:0] TOL_RESET = 16'd5898;
  localparam logic [PADDR_W-3:0] REG_TOL = '0;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Four points of one curve piece along a single axis.
  typedef struct packed {
    coord_t p0;
    coord_t p1;
    coord_t p2;
    coord_t p3;
  } curve4_t;

  typedef struct packed {
    curve4_t lo;
    curve4_t hi;
  } halves_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_SPLIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT,
    ST_POP
  } state_t;

  // Micro operations of the flatness test sequence.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIFF,
    OP_C1A,
    OP_C1B,
    OP_C2A,
    OP_C2B,
    OP_LA,
    OP_LB,
    OP_TLO,
    OP_THI,
    OP_MHH,
    OP_MHL,
    OP_MLL
  } flt_op_t;

  typedef struct packed {
    logic                 load;
    flt_op_t              op;
    logic                 split;
    logic                 div_init;
    logic                 div_step;
    logic                 emit;
    logic                 last;
    logic                 pop;
    logic [STK_IDX_W-1:0] stk_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic at_max;
    logic is_flat;
    logic out_free;
  } dp_sts_t;

  // Schedule of the flatness test: at most one multiply issued per step.
  function automatic flt_op_t op_at(logic [CNT_W-1:0] c);
    flt_op_t o;
    case (c)
      6'd0:    o = OP_DIFF;
      6'd1:    o = OP_C1A;
      6'd2:    o = OP_C1B;
      6'd3:    o = OP_C2A;
      6'd4:    o = OP_C2B;
      6'd5:    o = OP_LA;
      6'd6:    o = OP_LB;
      6'd8:    o = OP_TLO;
      6'd9:    o = OP_THI;
      6'd10:   o = OP_MHH;
      6'd11:   o = OP_MHL;
      6'd12:   o = OP_MLL;
      default: o = OP_NOP;
    endcase
    return o;
  endfunction

  // Midpoint rounded toward minus infinity.
  function automatic coord_t mid_pt(coord_t a, coord_t b);
    logic signed [COORD_W:0] s;
    s = (COORD_W+1)'(a) + (COORD_W+1)'(b);
    return s[COORD_W:1];
  endfunction

  // De Casteljau split at t = 1/2; the unused point stays zero for quadratics.
  function automatic halves_t split_c(curve4_t c, logic cubic);
    halves_t h;
    coord_t a, b, d, ab, bc, m, cq, mq;
    a  = mid_pt(c.p0, c.p1);
    b  = mid_pt(c.p1, c.p2);
    d  = mid_pt(c.p2, c.p3);
    ab = mid_pt(a, b);
    bc = mid_pt(b, d);
    m  = mid_pt(ab, bc);
    cq = mid_pt(c.p1, c.p3);
    mq = mid_pt(a, cq);
    if (cubic) begin
      h.lo = '{p0: c.p0, p1: a, p2: ab, p3: m};
      h.hi = '{p0: m, p1: bc, p2: d, p3: c.p3};
    end else begin
      h.lo = '{p0: c.p0, p1: a, p2: '0, p3: mq};
      h.hi = '{p0: mq, p1: cq, p2: '0, p3: c.p3};
    end
    return h;
  endfunction

endpackage

[hdl/bfe_in_if.sv]
// Input channel carrying one Bezier curve per transaction.
// Depends on bfe_pkg for the coordinate type.
interface bfe_in_if import bfe_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  coord_t start_x;
  coord_t start_y;
  coord_t ctrl1_x;
  coord_t ctrl1_y;
  coord_t ctrl2_x;
  coord_t ctrl2_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, cmd, start_x, start_y, ctrl1_x, ctrl1_y,
                  ctrl2_x, ctrl2_y, end_x, end_y, input ready);
  modport sink (input valid, cmd, start_x, start_y, ctrl1_x, ctrl1_y,
                ctrl2_x, ctrl2_y, end_x, end_y, output ready);
endinterface

[hdl/bfe_out_if.sv]
// Result channel carrying one scanline edge record per transaction.
// Depends on bfe_pkg for widths and the coordinate type.
interface bfe_out_if import bfe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  coord_t                    edge_top_y;
  coord_t                    edge_bottom_y;
  coord_t                    edge_top_x;
  logic signed [SLOPE_W-1:0] edge_slope;
  logic signed [1:0]         edge_dir;
  logic                      flat;
  logic                      last;

  modport source (output valid, edge_top_y, edge_bottom_y, edge_top_x, edge_slope,
                  edge_dir, flat, last, input ready);
  modport sink (input valid, edge_top_y, edge_bottom_y, edge_top_x, edge_slope,
                edge_dir, flat, last, output ready);
endinterface

[hdl/bfe_ctrl.sv]
// Sequencer of the flattener: walks the subdivision, test, divide and emit steps.
// Depends on bfe_pkg; drives the datapath by ctl_cmd_t and reads dp_sts_t.
module bfe_ctrl import bfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [STK_IDX_W-1:0]   sp_r, sp_nxt;
  logic [RES_CNT_W-1:0]   n_r, n_nxt;
  logic                   last;

  // The final edge comes when the stack is empty or the run is full.
  assign last = (sp_r == '0) || (n_r == {RES_CNT_W{1'b1}});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:    state_nxt = sts.at_max ? ST_DIV_INIT : ST_TEST;
      ST_TEST: begin
        if (cnt_r == CNT_W'(TEST_LAST)) begin
          state_nxt = sts.is_flat ? ST_DIV_INIT : ST_SPLIT;
        end
      end
      ST_SPLIT:    state_nxt = ST_CHECK;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = last ? ST_IDLE : ST_POP;
      end
      ST_POP:      state_nxt = ST_CHECK;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NOP;
    cmd.last     = last;
    cmd.stk_idx  = sp_r;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_TEST:     cmd.op = op_at(cnt_r);
      ST_SPLIT:    cmd.split = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_EMIT:     cmd.emit = sts.out_free;
      ST_POP: begin
        cmd.pop     = 1'b1;
        cmd.stk_idx = sp_r - 1'b1;
      end
      default: ;
    endcase
  end

  // Step counter, stack pointer and result count.
  always_comb begin
    cnt_nxt = cnt_r;
    sp_nxt  = sp_r;
    n_nxt   = n_r;
    case (state_r)
      ST_IDLE: begin
        sp_nxt = '0;
        n_nxt  = '0;
      end
      ST_CHECK, ST_DIV_INIT: cnt_nxt = '0;
      ST_TEST, ST_DIV:       cnt_nxt = cnt_r + 1'b1;
      ST_SPLIT:              sp_nxt = sp_r + 1'b1;
      ST_POP:                sp_nxt = sp_r - 1'b1;
      ST_EMIT:               if (sts.out_free) n_nxt = n_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sp_r    <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sp_r    <= sp_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

[hdl/bfe_datapath.sv]
// Datapath: current piece, pending stack, flatness multiply-accumulate,
// slope divider and result register. Depends on bfe_pkg and both channel interfaces.
module bfe_datapath import bfe_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfe_in_if.sink      in_ch,
  bfe_out_if.source   out_ch,
  input  logic [15:0] tolerance_sq,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts
);

  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Current piece and the pending stack.
  curve4_t           cx_r, cy_r;
  logic              cubic_r;
  logic [LVL_W-1:0]  lvl_r;
  curve4_t           stk_x_r   [MAX_DEPTH];
  curve4_t           stk_y_r   [MAX_DEPTH];
  logic [LVL_W-1:0]  stk_lvl_r [MAX_DEPTH];
  halves_t           hx, hy;
  logic [IDX_W-1:0]  idx;

  assign hx  = split_c(cx_r, cubic_r);
  assign hy  = split_c(cy_r, cubic_r);
  assign idx = cmd.stk_idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= '{p0: in_ch.start_x, p1: in_ch.ctrl1_x,
                   p2: in_ch.cmd ? in_ch.ctrl2_x : '0, p3: in_ch.end_x};
      cy_r    <= '{p0: in_ch.start_y, p1: in_ch.ctrl1_y,
                   p2: in_ch.cmd ? in_ch.ctrl2_y : '0, p3: in_ch.end_y};
      cubic_r <= in_ch.cmd;
      lvl_r   <= '0;
    end else if (cmd.split) begin
      stk_x_r[idx]   <= hx.hi;
      stk_y_r[idx]   <= hy.hi;
      stk_lvl_r[idx] <= lvl_r + 1'b1;
      cx_r           <= hx.lo;
      cy_r           <= hy.lo;
      lvl_r          <= lvl_r + 1'b1;
    end else if (cmd.pop) begin
      cx_r  <= stk_x_r[idx];
      cy_r  <= stk_y_r[idx];
      lvl_r <= stk_lvl_r[idx];
    end
  end

  // Chord and control point offsets for the flatness test.
  logic signed [COORD_W:0] dx_r, dy_r, e1x_r, e1y_r, e2x_r, e2y_r;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIFF) begin
      dx_r  <= (COORD_W+1)'(cx_r.p3) - (COORD_W+1)'(cx_r.p0);
      dy_r  <= (COORD_W+1)'(cy_r.p3) - (COORD_W+1)'(cy_r.p0);
      e1x_r <= (COORD_W+1)'(cx_r.p1) - (COORD_W+1)'(cx_r.p3);
      e1y_r <= (COORD_W+1)'(cy_r.p1) - (COORD_W+1)'(cy_r.p3);
      e2x_r <= (COORD_W+1)'(cx_r.p2) - (COORD_W+1)'(cx_r.p3);
      e2y_r <= (COORD_W+1)'(cy_r.p2) - (COORD_W+1)'(cy_r.p3);
    end
  end

  // Shared 26x26 multiplier with a registered product.
  logic signed [25:0] ma, mb;
  logic signed [51:0] p_r;
  flt_op_t            op_d_r;
  logic [99:0]        acc_r;
  logic [48:0]        m_r;
  logic [64:0]        rhs_r;

  always_comb begin
    case (cmd.op)
      OP_C1A:  begin ma = 26'(e1x_r); mb = 26'(dy_r); end
      OP_C1B:  begin ma = 26'(e1y_r); mb = 26'(dx_r); end
      OP_C2A:  begin ma = 26'(e2x_r); mb = 26'(dy_r); end
      OP_C2B:  begin ma = 26'(e2y_r); mb = 26'(dx_r); end
      OP_LA:   begin ma = 26'(dx_r);  mb = 26'(dx_r); end
      OP_LB:   begin ma = 26'(dy_r);  mb = 26'(dy_r); end
      OP_TLO:  begin ma = $signed({10'd0, tolerance_sq}); mb = $signed({1'b0, acc_r[24:0]}); end
      OP_THI:  begin ma = $signed({10'd0, tolerance_sq}); mb = $signed({2'b0, acc_r[48:25]}); end
      OP_MHH:  begin ma = $signed({2'b0, m_r[48:25]}); mb = $signed({2'b0, m_r[48:25]}); end
      OP_MHL:  begin ma = $signed({2'b0, m_r[48:25]}); mb = $signed({1'b0, m_r[24:0]}); end
      OP_MLL:  begin ma = $signed({1'b0, m_r[24:0]}); mb = $signed({1'b0, m_r[24:0]}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) op_d_r <= OP_NOP;
    else        op_d_r <= cmd.op;
  end

  // Accumulator: cross products, chord length, tolerance product and m squared.
  logic [99:0]        p_ext;
  logic signed [49:0] d_s;
  logic [48:0]        d_abs;

  assign p_ext = 100'(p_r);
  assign d_s   = acc_r[49:0];
  assign d_abs = d_s[49] ? 49'(-d_s) : d_s[48:0];

  always_ff @(posedge clk) begin
    case (op_d_r)
      OP_C1A: acc_r <= p_ext;
      OP_C1B: acc_r <= acc_r - p_ext;
      OP_C2A: begin
        m_r   <= d_abs;
        acc_r <= p_ext;
      end
      OP_C2B: acc_r <= acc_r - p_ext;
      OP_LA: begin
        if (cubic_r && (d_abs > m_r)) m_r <= d_abs;
        acc_r <= p_ext;
      end
      OP_LB:  acc_r <= acc_r + p_ext;
      OP_TLO: acc_r <= p_ext;
      OP_THI: acc_r <= acc_r + (p_ext << 25);
      OP_MHH: begin
        rhs_r <= acc_r[64:0];
        acc_r <= p_ext << 50;
      end
      OP_MHL: acc_r <= acc_r + (p_ext << 26);
      OP_MLL: acc_r <= acc_r + p_ext;
      default: ;
    endcase
  end

  // Edge geometry of the current piece's chord.
  logic                    flat, down;
  logic signed [COORD_W:0] dxe, dye;
  logic [COORD_W-1:0]      dx_mag, dy_mag;

  assign flat   = (cy_r.p0 == cy_r.p3);
  assign down   = (cy_r.p3 < cy_r.p0);
  assign dxe    = down ? ((COORD_W+1)'(cx_r.p0) - (COORD_W+1)'(cx_r.p3))
                       : ((COORD_W+1)'(cx_r.p3) - (COORD_W+1)'(cx_r.p0));
  assign dye    = (COORD_W+1)'(cy_r.p3) - (COORD_W+1)'(cy_r.p0);
  assign dx_mag = dxe[COORD_W] ? COORD_W'(-dxe) : dxe[COORD_W-1:0];
  assign dy_mag = dye[COORD_W] ? COORD_W'(-dye) : dye[COORD_W-1:0];

  // Restoring divider, one quotient bit per cycle; quotient shifts into num_r.
  logic [DIV_STEPS-1:0] num_r;
  logic [COORD_W-1:0]   rem_r, den_r;
  logic                 neg_r;
  logic [COORD_W:0]     trial;
  logic                 ge;

  assign trial = {rem_r, num_r[DIV_STEPS-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= {dx_mag, 16'd0};
      rem_r <= '0;
      den_r <= dy_mag;
      neg_r <= dxe[COORD_W];
    end else if (cmd.div_step) begin
      rem_r <= ge ? COORD_W'(trial - {1'b0, den_r}) : trial[COORD_W-1:0];
      num_r <= {num_r[DIV_STEPS-2:0], ge};
    end
  end

  // Saturate the quotient to the signed slope range.
  logic signed [SLOPE_W-1:0] slope;

  always_comb begin
    if (flat) begin
      slope = '0;
    end else if (neg_r) begin
      if ((|num_r[DIV_STEPS-1:SLOPE_W]) || (num_r[SLOPE_W-1] && (|num_r[SLOPE_W-2:0])))
        slope = {1'b1, {(SLOPE_W-1){1'b0}}};
      else
        slope = -$signed(num_r[SLOPE_W-1:0]);
    end else begin
      if (|num_r[DIV_STEPS-1:SLOPE_W-1]) slope = {1'b0, {(SLOPE_W-1){1'b1}}};
      else                               slope = $signed(num_r[SLOPE_W-1:0]);
    end
  end

  // Result register; a new edge may load in the cycle the old one is taken.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch.edge_top_y    <= down ? cy_r.p3 : cy_r.p0;
      out_ch.edge_bottom_y <= down ? cy_r.p0 : cy_r.p3;
      out_ch.edge_top_x    <= down ? cx_r.p3 : cx_r.p0;
      out_ch.edge_slope    <= slope;
      out_ch.edge_dir      <= flat ? 2'sd0 : (down ? -2'sd1 : 2'sd1);
      out_ch.flat          <= flat;
      out_ch.last          <= cmd.last;
    end
  end

  assign out_ch.valid = out_valid_r;

  assign sts.at_max   = (lvl_r >= LVL_W'(MAX_DEPTH));
  assign sts.is_flat  = (acc_r < {35'd0, rhs_r});
  assign sts.out_free = !out_valid_r || out_ch.ready;

endmodule

[hdl/bezier_flatten_to_edges_top.sv]
// Top level of the Bezier curve to scanline edge flattener.
// Depends on bfe_pkg, bfe_in_if, bfe_out_if, bfe_ctrl and bfe_datapath.
//
//  channel | direction | handshake            | one transaction
//  in_ch   | in        | valid/ready          | one quadratic or cubic curve
//  out_ch  | out       | valid/ready          | one edge record, last on the final one
//  APB     | in        | psel/penable/pready  | tolerance_sq write or read
//
// A curve is processed one at a time and is accepted only while the block is idle.
// Each piece passes a check and, below the depth limit, a flatness test on the shared
// multiplier; a piece that is not flat is split. Each emitted edge passes the bit-serial
// slope divider, then an emit step and, unless it is the last, a pop step.
// Output stalls hold the sequencer in its emit step. Reset is synchronous.
module bezier_flatten_to_edges_top import bfe_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  bfe_in_if.sink             in_ch,
  bfe_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] tol_r;
  logic        in_ready;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;
  logic        reg_hit;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_TOL);
  assign prdata  = reg_hit ? {16'd0, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      tol_r <= pwdata[15:0];
    end
  end

  assign in_ch.ready = in_ready;

  bfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfe_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .tolerance_sq (tol_r),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

[dv/bezier_flatten_to_edges_top_tb.sv]
// Testbench for the Bezier curve to scanline edge flattener.
// Depends on bfe_pkg, bfe_in_if, bfe_out_if and bezier_flatten_to_edges_top.
// Curves are predicted by subdivision in the bench and checked edge by edge.
module bezier_flatten_to_edges_top_tb;
  import bfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH_LIMIT = MAX_DEPTH_DEF;
  localparam longint      CYCLE_LIMIT = 20000000;
  localparam logic [PADDR_W-1:0] TOL_ADDR = {REG_TOL, 2'b00};
  localparam logic        CMD_QUAD  = 1'b0;
  localparam logic        CMD_CUBIC = 1'b1;

  typedef struct packed {
    logic   cmd;
    coord_t sx, sy, c1x, c1y, c2x, c2y, ex, ey;
  } curve_t;

  localparam int CURVE_W = $bits(curve_t);

  typedef struct packed {
    coord_t                    top_y;
    coord_t                    bottom_y;
    coord_t                    top_x;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [1:0]         dir;
    logic                      flat;
    logic                      last;
  } edge_rec_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  bfe_in_if  in_ch();
  bfe_out_if out_ch();

  bezier_flatten_to_edges_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  edge_rec_t   pending_edges[$];
  logic [15:0] tol_model;
  int          errors;
  int          curves_sent;
  int          edges_seen;
  int          flat_seen;
  longint      cycles;
  bit          no_idle;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Gap length: mostly short, a few long, none in free-running stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Builds one edge record from the endpoints of an accepted line.
  function automatic edge_rec_t make_edge(longint x0, longint y0, longint x1, longint y1,
                                          bit is_last);
    edge_rec_t e;
    longint num, den, q;
    e.last = is_last;
    if (y0 == y1) begin
      e.top_y = coord_t'(y0); e.bottom_y = coord_t'(y0); e.top_x = coord_t'(x0);
      e.slope = '0; e.dir = 2'sd0; e.flat = 1'b1;
    end else begin
      e.flat = 1'b0;
      if (y0 < y1) begin
        e.top_y = coord_t'(y0); e.bottom_y = coord_t'(y1); e.top_x = coord_t'(x0);
        e.dir = 2'sd1; num = (x1 - x0) * 65536; den = y1 - y0;
      end else begin
        e.top_y = coord_t'(y1); e.bottom_y = coord_t'(y0); e.top_x = coord_t'(x1);
        e.dir = -2'sd1; num = (x0 - x1) * 65536; den = y0 - y1;
      end
      q = num / den;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      e.slope = SLOPE_W'(q);
    end
    return e;
  endfunction

  // Flatness: squared max cross product below tolerance times squared chord.
  function automatic bit piece_is_line(longint px[4], longint py[4], bit cubic);
    longint dx, dy, d1, d2, m, len;
    logic [127:0] lhs, rhs;
    dx = px[3] - px[0];
    dy = py[3] - py[0];
    d1 = (px[1] - px[3]) * dy - (py[1] - py[3]) * dx;
    m = (d1 < 0) ? -d1 : d1;
    if (cubic) begin
      d2 = (px[2] - px[3]) * dy - (py[2] - py[3]) * dx;
      if (d2 < 0) d2 = -d2;
      if (d2 > m) m = d2;
    end
    len = dx * dx + dy * dy;
    lhs = 128'(m);
    lhs = lhs * lhs;
    rhs = 128'(tol_model);
    rhs = rhs * 128'(len);
    return lhs < rhs;
  endfunction

  // Depth-first midpoint subdivision; queues every edge of one curve in order.
  function automatic void flatten_curve(curve_t c);
    longint px[4], py[4], lx[4], ly[4], rx[4], ry[4];
    longint sx[6][4], sy[6][4];
    longint ax, ay, bx, by, cx, cy, abx, aby, bcx, bcy, mx, my;
    int     slvl[6];
    int     level, top, n;
    bit     cubic, is_last;
    cubic = c.cmd;
    px[0] = c.sx;  py[0] = c.sy;
    px[1] = c.c1x; py[1] = c.c1y;
    px[2] = cubic ? longint'(c.c2x) : 0;
    py[2] = cubic ? longint'(c.c2y) : 0;
    px[3] = c.ex;  py[3] = c.ey;
    level = 0; top = 0; n = 0;
    forever begin
      if (level >= DEPTH_LIMIT || piece_is_line(px, py, cubic)) begin
        is_last = (top == 0) || (n >= 63);
        pending_edges.insert(pending_edges.size(),
                             make_edge(px[0], py[0], px[3], py[3], is_last));
        n++;
        if (is_last) break;
        top--;
        px = sx[top]; py = sy[top]; level = slvl[top];
      end else if (top >= 6) begin
        level = DEPTH_LIMIT;
      end else begin
        ax = (px[0] + px[1]) >>> 1; ay = (py[0] + py[1]) >>> 1;
        if (cubic) begin
          bx = (px[1] + px[2]) >>> 1; by = (py[1] + py[2]) >>> 1;
          cx = (px[2] + px[3]) >>> 1; cy = (py[2] + py[3]) >>> 1;
          abx = (ax + bx) >>> 1;  aby = (ay + by) >>> 1;
          bcx = (bx + cx) >>> 1;  bcy = (by + cy) >>> 1;
          mx = (abx + bcx) >>> 1; my = (aby + bcy) >>> 1;
          lx = '{px[0], ax, abx, mx};  ly = '{py[0], ay, aby, my};
          rx = '{mx, bcx, cx, px[3]};  ry = '{my, bcy, cy, py[3]};
        end else begin
          cx = (px[1] + px[3]) >>> 1; cy = (py[1] + py[3]) >>> 1;
          mx = (ax + cx) >>> 1;       my = (ay + cy) >>> 1;
          lx = '{px[0], ax, 0, mx};    ly = '{py[0], ay, 0, my};
          rx = '{mx, cx, 0, px[3]};    ry = '{my, cy, 0, py[3]};
        end
        sx[top] = rx; sy[top] = ry; slvl[top] = level + 1;
        top++;
        px = lx; py = ly;
        level++;
      end
    end
  endfunction

  // Sends one curve after a random gap and predicts its edges on acceptance.
  task automatic send_curve(curve_t c);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.cmd = c.cmd;
    in_ch.start_x = c.sx;  in_ch.start_y = c.sy;
    in_ch.ctrl1_x = c.c1x; in_ch.ctrl1_y = c.c1y;
    in_ch.ctrl2_x = c.c2x; in_ch.ctrl2_y = c.c2y;
    in_ch.end_x = c.ex;    in_ch.end_y = c.ey;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    flatten_curve(c);
    curves_sent++;
  endtask

  // Drops valid and waits until every predicted edge has arrived.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // APB write of the tolerance register, then a read back of it.
  task automatic set_tolerance(logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = TOL_ADDR; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tol_model = value[15:0];
    @(negedge clk);
    penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== tol_model) begin
      $error("tolerance_sq: expected %0d, actual %0d", tol_model, prdata[15:0]);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic curve_t mk(logic cmd, coord_t sx, coord_t sy, coord_t c1x, coord_t c1y,
                                coord_t c2x, coord_t c2y, coord_t ex, coord_t ey);
    curve_t c;
    c = '{cmd, sx, sy, c1x, c1y, c2x, c2y, ex, ey};
    return c;
  endfunction

  function automatic coord_t near(coord_t base, int span);
    return coord_t'(longint'(base) + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random curve: mostly local curves of varied size, plus full-range noise,
  // horizontal runs and degenerate chords.
  function automatic curve_t random_curve();
    curve_t c;
    coord_t b;
    int r, span;
    r = $urandom_range(0, 99);
    span = (r % 3 == 0) ? $urandom_range(256, 16384) : $urandom_range(4, 2048);
    b = coord_t'($urandom_range(0, 2097151)) - coord_t'(1048576);
    c.cmd = 1'($urandom_range(0, 1));
    c.sx = near(b, span); c.sy = near(b, span);
    c.c1x = near(b, span); c.c1y = near(b, span);
    c.c2x = near(b, span); c.c2y = near(b, span);
    c.ex = near(b, span); c.ey = near(b, span);
    if (r >= 70 && r < 85) begin
      c = curve_t'(CURVE_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom}));
    end else if (r >= 85 && r < 92) begin
      c.c1y = c.sy; c.c2y = c.sy; c.ey = c.sy;
    end else if (r >= 92) begin
      c.ex = c.sx; c.ey = c.sy;
    end
    return c;
  endfunction

  // Directed curves: extremes, both kinds, horizontal, vertical, degenerate.
  task automatic test_directed();
    coord_t mx, mn;
    mx = coord_t'(24'h7FFFFF);
    mn = coord_t'(24'h800000);
    send_curve(mk(CMD_QUAD, 0, 0, 256, 0, 0, 0, 512, 512));
    send_curve(mk(CMD_CUBIC, 0, 0, 0, 2560, 2560, 2560, 2560, 0));
    send_curve(mk(CMD_QUAD, 100, 300, 500, 300, mx, mn, 900, 300));
    send_curve(mk(CMD_CUBIC, -256, 40, 0, 40, 256, 40, 1024, 40));
    send_curve(mk(CMD_QUAD, 50, -1000, 50, 0, 0, 0, 50, 1000));
    send_curve(mk(CMD_CUBIC, 700, 700, 900, 100, 100, 900, 700, 700));
    send_curve(mk(CMD_QUAD, 10, 10, 10, 10, 0, 0, 10, 10));
    send_curve(mk(CMD_CUBIC, mn, mn, mx, mn, mn, mx, mx, mx));
    send_curve(mk(CMD_QUAD, mx, mx, mn, mx, 0, 0, mn, mn));
    send_curve(mk(CMD_CUBIC, mn, 0, mn, 0, mx, 1, mx, 1));
    send_curve(mk(CMD_CUBIC, mx, 5, mx, 5, mn, 4, mn, 4));
    send_curve(mk(CMD_QUAD, mn, mn, mn, mn, 0, 0, mx, mn));
    send_curve(mk(CMD_QUAD, 0, 2000, 1000, 0, -1, -1, 2000, 2000));
    send_curve(mk(CMD_CUBIC, 3000, 0, -3000, 1000, 3000, 2000, -3000, 3000));
    send_curve(mk(CMD_CUBIC, -1, -1, -1, -1, -1, -1, -1, -1));
    send_curve(mk(CMD_QUAD, 0, 0, 0, 0, mx, mx, 0, 0));
    drain();
  endtask

  // Random curves under one tolerance, with a free-running stretch.
  task automatic test_random(logic [31:0] tol, int count);
    set_tolerance(tol);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      send_curve(random_curve());
    end
    no_idle = 1'b0;
    drain();
  endtask

  // Result ready with random stalls.
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else begin
        stall = pick_gap();
        out_ch.ready = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Compares each edge transaction against the oldest prediction.
  always @(posedge clk) begin
    edge_rec_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      edges_seen++;
      if (out_ch.flat) flat_seen++;
      if (pending_edges.size() == 0) begin
        $error("edge transaction with no prediction waiting");
        errors++;
      end else begin
        e = pending_edges.pop_front();
        if (out_ch.edge_top_y !== e.top_y) begin
          $error("edge_top_y: expected %0d, actual %0d", e.top_y, out_ch.edge_top_y);
          errors++;
        end
        if (out_ch.edge_bottom_y !== e.bottom_y) begin
          $error("edge_bottom_y: expected %0d, actual %0d", e.bottom_y, out_ch.edge_bottom_y);
          errors++;
        end
        if (out_ch.edge_top_x !== e.top_x) begin
          $error("edge_top_x: expected %0d, actual %0d", e.top_x, out_ch.edge_top_x);
          errors++;
        end
        if (out_ch.edge_slope !== e.slope) begin
          $error("edge_slope: expected %0d, actual %0d", e.slope, out_ch.edge_slope);
          errors++;
        end
        if (out_ch.edge_dir !== e.dir) begin
          $error("edge_dir: expected %0d, actual %0d", e.dir, out_ch.edge_dir);
          errors++;
        end
        if (out_ch.flat !== e.flat) begin
          $error("flat: expected %0d, actual %0d", e.flat, out_ch.flat);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    errors = 0; curves_sent = 0; edges_seen = 0; flat_seen = 0; cycles = 0;
    no_idle = 1'b0;
    tol_model = TOL_RESET;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.cmd = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.ctrl1_x = '0; in_ch.ctrl1_y = '0;
    in_ch.ctrl2_x = '0; in_ch.ctrl2_y = '0; in_ch.end_x = '0; in_ch.end_y = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(32'hFFFF_0000 | 32'd65535, 60);
    test_random(32'd0, 30);
    test_random(32'h0001_0000 | $urandom_range(1, 65534), 60);
    test_random(32'd1, 30);
    test_random({16'hA5A5, TOL_RESET}, 60);
    while (pending_edges.size() != 0) @(posedge clk);
    $display("Ran %0d curves, checked %0d edges (%0d horizontal).",
             curves_sent, edges_seen, flat_seen);
    $display("Tolerance went through zero, one, full scale, reset and a random value.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bfe_pkg.sv
hdl/bfe_in_if.sv
hdl/bfe_out_if.sv
hdl/bfe_ctrl.sv
hdl/bfe_datapath.sv
hdl/bezier_flatten_to_edges_top.sv
dv/bezier_flatten_to_edges_top_tb.sv
